[rtl/bpk_pkg.sv]
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types and constants of the msb-first bit packer.
// ----------------------------------------------------------------------------
package bpk_pkg;

  localparam int WORD_W   = 8;   // bits in one output word
  localparam int VALUE_W  = 64;  // field value width
  localparam int COUNT_W  = 7;   // bit count width
  localparam int MAX_BITS = 64;  // widest legal field
  localparam int PEND_W   = 7;   // most bits left over between items
  localparam int FILL_W   = 3;   // width of pending bit count
  localparam int NB_W     = 4;   // number of words one item yields, 0..8
  localparam int IDX_W    = 3;   // index of a word in the output buffer
  localparam int STREAM_W = PEND_W + VALUE_W;

  // item kinds
  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_ALIGN  = 1'b1
  } mode_t;

  // leftover bits between items, oldest bit highest
  typedef struct packed {
    logic [PEND_W-1:0] bits;
    logic [FILL_W-1:0] fill;
  } pend_state_t;

  // words produced by one item, first word in the highest used byte
  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic [NB_W-1:0]    nwords;
    logic               bad;
  } pack_res_t;

endpackage

[rtl/bpk_in_if.sv]
// ----------------------------------------------------------------------------
// bpk_in_if
// Input channel: valid/ready handshake with one field item.
// ----------------------------------------------------------------------------
interface bpk_in_if;
  import bpk_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [VALUE_W-1:0] field_value;
  logic [COUNT_W-1:0] bit_count;

  modport source (output valid, mode, field_value, bit_count, input ready);
  modport sink   (input valid, mode, field_value, bit_count, output ready);
endinterface

[rtl/bpk_out_if.sv]
// ----------------------------------------------------------------------------
// bpk_out_if
// Output channel: valid/ready handshake with one packed word.
// ----------------------------------------------------------------------------
interface bpk_out_if;
  import bpk_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_byte;
  logic              is_last;
  logic              bad_width;

  modport source (output valid, out_byte, is_last, bad_width, input ready);
  modport sink   (input valid, out_byte, is_last, bad_width, output ready);
endinterface

[rtl/bpk_pack.sv]
// ----------------------------------------------------------------------------
// bpk_pack
// Merges a registered item with the leftover bits into whole words plus the new
// leftover; an align item pads the leftover, a bad width gives one flagged word.
// ----------------------------------------------------------------------------
module bpk_pack (
  input  logic                         mode,
  input  logic [bpk_pkg::VALUE_W-1:0]  field_value,
  input  logic [bpk_pkg::COUNT_W-1:0]  bit_count,
  input  bpk_pkg::pend_state_t         pend,
  output bpk_pkg::pend_state_t         pend_next,
  output bpk_pkg::pack_res_t           res
);
  import bpk_pkg::*;

  logic [VALUE_W-1:0]  masked;
  logic [STREAM_W-1:0] stream;
  logic [STREAM_W-1:0] aligned;
  logic [COUNT_W:0]    total;
  logic [FILL_W-1:0]   rem;
  logic [WORD_W-1:0]   pad_word;
  logic                width_bad;

  // bit stream: leftover bits followed by the low bit_count bits of the value
  assign masked    = field_value & ~({VALUE_W{1'b1}} << bit_count);
  assign stream    = (STREAM_W'(pend.bits) << bit_count) | STREAM_W'(masked);
  assign total     = (COUNT_W+1)'(pend.fill) + (COUNT_W+1)'(bit_count);
  assign rem       = total[FILL_W-1:0];
  assign aligned   = stream >> rem;
  assign width_bad = (bit_count == '0) || (bit_count > COUNT_W'(MAX_BITS));

  // leftover bits moved up to the top of a zero-padded word
  assign pad_word  = WORD_W'(WORD_W'(pend.bits) << (NB_W'(WORD_W) - NB_W'(pend.fill)));

  // select by item kind
  always_comb begin
    pend_next  = pend;
    res.data   = '0;
    res.nwords = '0;
    res.bad    = 1'b0;
    if (mode == MODE_ALIGN) begin
      if (pend.fill != '0) begin
        res.data   = VALUE_W'(pad_word);
        res.nwords = NB_W'(1);
      end
      pend_next = '0;
    end else if (width_bad) begin
      res.nwords = NB_W'(1);
      res.bad    = 1'b1;
    end else begin
      res.data       = aligned[VALUE_W-1:0];
      res.nwords     = total[COUNT_W-1:FILL_W];
      pend_next.bits = stream[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
      pend_next.fill = rem;
    end
  end

endmodule

[rtl/bpk_out_buf.sv]
// ----------------------------------------------------------------------------
// bpk_out_buf
// Holds the words of one item and hands them out one per cycle while the
// receiver is ready, first word first.
// ----------------------------------------------------------------------------
module bpk_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  bpk_pkg::pack_res_t res,
  output logic               can_load,
  bpk_out_if.source          out_item
);
  import bpk_pkg::*;

  logic [VALUE_W-1:0] data;
  logic [IDX_W-1:0]   idx;
  logic               bad;
  logic               busy;
  logic               take;

  assign take     = busy && out_item.ready;
  assign can_load = !busy || (take && (idx == '0));

  // word counter and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load && can_load) begin
      busy <= (res.nwords != '0);
      idx  <= IDX_W'(res.nwords - NB_W'(1));
    end else if (take) begin
      if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data <= res.data;
      bad  <= res.bad;
    end
  end

  // output word, highest stored word goes first
  assign out_item.valid     = busy;
  assign out_item.out_byte  = data[idx*WORD_W +: WORD_W];
  assign out_item.is_last   = (idx == '0);
  assign out_item.bad_width = bad;

`ifndef ASSERT_OFF
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("item loaded while output buffer still busy");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    take && (idx != '0) |=> busy && (idx == $past(idx) - IDX_W'(1)))
    else $error("word index did not step down after a taken word");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    busy && bad |-> (idx == '0) && (data == '0))
    else $error("bad width result is not a single zero word");

  a_never_wider: assert property (@(posedge clk) disable iff (rst)
    load && !res.bad && (res.nwords > NB_W'(VALUE_W / WORD_W)) |-> 1'b0)
    else $error("item produced more words than the buffer holds");
`endif

endmodule

[rtl/msb_first_bit_packer.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-width fields msb first into a stream of 8-bit words.
// Path: an accepted item waits in the input register, then its words in the
//   output buffer, which holds them while the output stalls.
// Throughput: the output buffer drains one word per cycle while the output is
//   ready, and loads the next item as its last word is taken.
// Reset: synchronous rst empties both registers and clears leftover bits.
// ----------------------------------------------------------------------------
module msb_first_bit_packer (
  input  logic      clk,
  input  logic      rst,
  bpk_in_if.sink    in_item,
  bpk_out_if.source out_item
);
  import bpk_pkg::*;

  logic               iv;
  logic               imode;
  logic [VALUE_W-1:0] ivalue;
  logic [COUNT_W-1:0] icount;
  pend_state_t        pend;
  pend_state_t        pend_next;
  pack_res_t          res;
  logic               can_load;
  logic               advance;

  assign advance       = iv && can_load;
  assign in_item.ready = !iv || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_item.ready) begin
      iv <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.ready && in_item.valid) begin
      imode  <= in_item.mode;
      ivalue <= in_item.field_value;
      icount <= in_item.bit_count;
    end
  end

  // leftover bits between items
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (advance) begin
      pend <= pend_next;
    end
  end

  bpk_pack u_pack (
    .mode        (imode),
    .field_value (ivalue),
    .bit_count   (icount),
    .pend        (pend),
    .pend_next   (pend_next),
    .res         (res)
  );

  bpk_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .can_load (can_load),
    .out_item (out_item)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the msb-first bit packer. A queue of field items
// (directed corner cases, then random writes, aligns and bad widths) feeds
// a falling-edge driver. Every accepted item runs through a bit-serial
// predictor that keeps its own leftover bits. A rising-edge monitor checks
// each output word against the oldest predicted word. Both sides idle in
// several phases.
// ----------------------------------------------------------------------------
module tb;
  import bpk_pkg::*;

  // idle phases of the stimulus
  localparam logic [1:0] PH_STEADY     = 2'd0;
  localparam logic [1:0] PH_SEND_IDLE  = 2'd1;
  localparam logic [1:0] PH_RECV_STALL = 2'd2;
  localparam logic [1:0] PH_BOTH_IDLE  = 2'd3;

  localparam int N_RANDOM   = 410;
  localparam int PHASE_LEN  = 50;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    mode_t              mode;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               drain;   // hold off until no word is outstanding
    logic [1:0]         phase;
  } field_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              last;
    logic              bad;
  } packed_word_t;

  logic clk;
  logic rst;

  bpk_in_if  in_ch ();
  bpk_out_if out_ch ();

  msb_first_bit_packer DUT (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  field_item_t  field_queue[$];
  packed_word_t expected_words[$];
  field_item_t  next_field;
  logic [PEND_W-1:0] pend_bits;
  logic [FILL_W-1:0] pend_fill;
  logic         item_held;
  logic [1:0]   rx_phase;
  logic [1:0]   stim_phase;
  int           mismatch_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int send_idle_pct(input logic [1:0] ph);
    case (ph)
      PH_SEND_IDLE: return 61;
      PH_BOTH_IDLE: return 17;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input logic [1:0] ph);
    case (ph)
      PH_RECV_STALL: return 61;
      PH_BOTH_IDLE:  return 17;
      default:       return 0;
    endcase
  endfunction

  function automatic packed_word_t make_word(input logic [WORD_W-1:0] d, input logic l,
                                             input logic b);
    packed_word_t w;
    w.data = d;
    w.last = l;
    w.bad  = b;
    return w;
  endfunction

  // bit-serial prediction of the words one item yields
  task automatic pack_field(input mode_t m, input logic [VALUE_W-1:0] v,
                            input logic [COUNT_W-1:0] c);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] words [0:7];
    int fill;
    int n;
    int i;
    acc  = {1'b0, pend_bits};
    fill = int'(pend_fill);
    n    = 0;
    if (m == MODE_ALIGN) begin
      // pad leftover bits with zeros; nothing to do when aligned
      if (fill != 0) begin
        acc = acc << (WORD_W - fill);
        expected_words.push_back(make_word(acc, 1'b1, 1'b0));
        pend_bits = '0;
        pend_fill = '0;
      end
    end else if (c == 0 || c > MAX_BITS) begin
      // bad width: one flagged word, leftover bits untouched
      expected_words.push_back(make_word('0, 1'b1, 1'b1));
    end else begin
      for (i = int'(c) - 1; i >= 0; i--) begin
        acc = {acc[WORD_W-2:0], v[i]};
        fill++;
        if (fill == WORD_W) begin
          words[n] = acc;
          n++;
          acc  = '0;
          fill = 0;
        end
      end
      for (i = 0; i < n; i++)
        expected_words.push_back(make_word(words[i], i == n - 1, 1'b0));
      pend_bits = acc[PEND_W-1:0];
      pend_fill = fill[FILL_W-1:0];
    end
  endtask

  task automatic add_field(input mode_t m, input logic [VALUE_W-1:0] v,
                           input logic [COUNT_W-1:0] c, input logic drain);
    field_item_t f;
    f.mode  = m;
    f.value = v;
    f.count = c;
    f.drain = drain;
    f.phase = stim_phase;
    field_queue.push_back(f);
  endtask

  // driver: present the next field item at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!item_held) begin
      if (field_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        next_field = field_queue[0];
        if (next_field.drain && expected_words.size() != 0) begin
          in_ch.valid <= 1'b0;
        end else if ($urandom_range(99) < send_idle_pct(next_field.phase)) begin
          in_ch.valid <= 1'b0;
        end else begin
          void'(field_queue.pop_front());
          in_ch.mode        <= next_field.mode;
          in_ch.field_value <= next_field.value;
          in_ch.bit_count   <= next_field.count;
          in_ch.valid       <= 1'b1;
          item_held = 1'b1;
          rx_phase  = next_field.phase;
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct(rx_phase));
  end

  // monitor: check each output word, then predict from each accepted item
  always @(posedge clk) begin
    packed_word_t exp_w;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word byte=%h last=%b bad=%b", $time,
                   out_ch.out_byte, out_ch.is_last, out_ch.bad_width);
          mismatch_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.out_byte !== exp_w.data || out_ch.is_last !== exp_w.last ||
              out_ch.bad_width !== exp_w.bad) begin
            $display({"%0t: word mismatch expected byte=%h last=%b bad=%b,",
                      " got byte=%h last=%b bad=%b"},
                     $time, exp_w.data, exp_w.last, exp_w.bad,
                     out_ch.out_byte, out_ch.is_last, out_ch.bad_width);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pack_field(mode_t'(in_ch.mode), in_ch.field_value, in_ch.bit_count);
        item_held = 1'b0;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int k;
    int r;
    int w;
    logic [COUNT_W-1:0] cnt;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_APPEND;
    in_ch.field_value = '0;
    in_ch.bit_count   = '0;
    out_ch.ready      = 1'b0;
    pend_bits         = '0;
    pend_fill         = '0;
    item_held         = 1'b0;
    rx_phase          = PH_STEADY;
    stim_phase        = PH_STEADY;
    mismatch_count    = 0;

    // directed corners
    add_field(MODE_ALIGN,  64'h0, 7'd0, 1'b0);                       // align when aligned
    add_field(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b0);
    add_field(MODE_APPEND, 64'h0, 7'd64, 1'b0);
    add_field(MODE_APPEND, 64'h8000_0000_0000_0001, 7'd64, 1'b0);
    add_field(MODE_APPEND, 64'h1, 7'd1, 1'b0);                       // partial byte
    add_field(MODE_ALIGN,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0);   // fields ignored
    add_field(MODE_APPEND, 64'h7F, 7'd7, 1'b0);
    add_field(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFE, 7'd1, 1'b0);     // upper bits ignored
    add_field(MODE_APPEND, 64'h5, 7'd3, 1'b0);
    add_field(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b0);     // bad width zero
    add_field(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd65, 1'b0);
    add_field(MODE_APPEND, 64'h0, 7'd127, 1'b0);
    add_field(MODE_APPEND, 64'h1A, 7'd5, 1'b1);                      // leftover bits kept
    add_field(MODE_APPEND, 64'hA5, 7'd8, 1'b0);
    add_field(MODE_APPEND, 64'h3, 7'd2, 1'b0);
    add_field(MODE_ALIGN,  64'h0, 7'd0, 1'b0);                       // align, bad count
    add_field(MODE_APPEND, 64'h55, 7'd7, 1'b0);
    add_field(MODE_APPEND, 64'hDEAD_BEEF_0123_4567, 7'd64, 1'b0);    // eight words
    add_field(MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, 7'd63, 1'b0);
    add_field(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFF0, 7'd4, 1'b0);
    add_field(MODE_ALIGN,  64'h1234, 7'd64, 1'b0);

    // random part, rotating through the idle phases
    for (k = 0; k < N_RANDOM; k++) begin
      stim_phase = 2'((k / PHASE_LEN) % 4);
      r = $urandom_range(99);
      if (r < 8) begin
        cnt = 7'($urandom_range(127));
        add_field(MODE_ALIGN, {$urandom, $urandom}, cnt, k % PHASE_LEN == 0);
      end else if (r < 13) begin
        cnt = ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(127, 65));
        add_field(MODE_APPEND, {$urandom, $urandom}, cnt, k % PHASE_LEN == 0);
      end else begin
        w = $urandom_range(99);
        if (w < 30)
          cnt = 7'($urandom_range(8, 1));
        else if (w < 85)
          cnt = 7'($urandom_range(64, 1));
        else
          cnt = 7'($urandom_range(64, 57));
        add_field(MODE_APPEND, {$urandom, $urandom}, cnt, k % PHASE_LEN == 0);
      end
    end

    // reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (field_queue.size() != 0 || item_held)
      @(posedge clk);
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #2400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/bpk_pkg.sv
rtl/bpk_in_if.sv
rtl/bpk_out_if.sv
rtl/bpk_pack.sv
rtl/bpk_out_buf.sv
rtl/msb_first_bit_packer.sv
test/tb.sv
